// ===== design/u2e_pkg.sv =====
// Shared types, status codes and the I8-to-EBCDIC byte table for the UTF-8 to UTF-EBCDIC converter.
package u2e_pkg;

  // Result status codes.
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_ILLEGAL    = 2'd1;
  localparam logic [1:0] ST_INCOMPLETE = 2'd2;

  // Depth of the command queue between the decoder and the encoder.
  localparam int CMD_DEPTH = 2;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  // One command for the encoder: a checked code point or an error.
  // trail is the number of I8 trailer bytes that follow the lead (0..4).
  typedef struct packed {
    logic [1:0]  status;
    logic [20:0] cp;
    logic [2:0]  trail;
  } cmd_t;

  // UTR#16 I8-to-EBCDIC mapping.
  localparam logic [7:0] I8_ROM [256] = '{
    8'h00,8'h01,8'h02,8'h03,8'h37,8'h2D,8'h2E,8'h2F,8'h16,8'h05,8'h15,8'h0B,8'h0C,8'h0D,8'h0E,8'h0F,
    8'h10,8'h11,8'h12,8'h13,8'h3C,8'h3D,8'h32,8'h26,8'h18,8'h19,8'h3F,8'h27,8'h1C,8'h1D,8'h1E,8'h1F,
    8'h40,8'h5A,8'h7F,8'h7B,8'h5B,8'h6C,8'h50,8'h7D,8'h4D,8'h5D,8'h5C,8'h4E,8'h6B,8'h60,8'h4B,8'h61,
    8'hF0,8'hF1,8'hF2,8'hF3,8'hF4,8'hF5,8'hF6,8'hF7,8'hF8,8'hF9,8'h7A,8'h5E,8'h4C,8'h7E,8'h6E,8'h6F,
    8'h7C,8'hC1,8'hC2,8'hC3,8'hC4,8'hC5,8'hC6,8'hC7,8'hC8,8'hC9,8'hD1,8'hD2,8'hD3,8'hD4,8'hD5,8'hD6,
    8'hD7,8'hD8,8'hD9,8'hE2,8'hE3,8'hE4,8'hE5,8'hE6,8'hE7,8'hE8,8'hE9,8'hAD,8'hE0,8'hBD,8'h5F,8'h6D,
    8'h79,8'h81,8'h82,8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,8'h91,8'h92,8'h93,8'h94,8'h95,8'h96,
    8'h97,8'h98,8'h99,8'hA2,8'hA3,8'hA4,8'hA5,8'hA6,8'hA7,8'hA8,8'hA9,8'hC0,8'h4F,8'hD0,8'hA1,8'h07,
    8'h20,8'h21,8'h22,8'h23,8'h24,8'h25,8'h06,8'h17,8'h28,8'h29,8'h2A,8'h2B,8'h2C,8'h09,8'h0A,8'h1B,
    8'h30,8'h31,8'h1A,8'h33,8'h34,8'h35,8'h36,8'h08,8'h38,8'h39,8'h3A,8'h3B,8'h04,8'h14,8'h3E,8'hFF,
    8'h41,8'h42,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,8'h4A,8'h51,8'h52,8'h53,8'h54,8'h55,8'h56,
    8'h57,8'h58,8'h59,8'h62,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,8'h6A,8'h70,8'h71,8'h72,8'h73,
    8'h74,8'h75,8'h76,8'h77,8'h78,8'h80,8'h8A,8'h8B,8'h8C,8'h8D,8'h8E,8'h8F,8'h90,8'h9A,8'h9B,8'h9C,
    8'h9D,8'h9E,8'h9F,8'hA0,8'hAA,8'hAB,8'hAC,8'hAE,8'hAF,8'hB0,8'hB1,8'hB2,8'hB3,8'hB4,8'hB5,8'hB6,
    8'hB7,8'hB8,8'hB9,8'hBA,8'hBB,8'hBC,8'hBE,8'hBF,8'hCA,8'hCB,8'hCC,8'hCD,8'hCE,8'hCF,8'hDA,8'hDB,
    8'hDC,8'hDD,8'hDE,8'hDF,8'hE1,8'hEA,8'hEB,8'hEC,8'hED,8'hEE,8'hEF,8'hFA,8'hFB,8'hFC,8'hFD,8'hFE
  };

endpackage

// ===== design/utf8_to_utf_ebcdic_converter.sv =====
// Top level of the UTF-8 to UTF-EBCDIC converter.
//
// Input side: a queue-style write port. A beat carries one UTF-8 byte and an
// end-of-buffer flag, and is taken at a rising edge with in_push high and
// in_full low. A byte can be taken every cycle while the command queue has room.
// Output side: a queue-style read port. While out_empty is low the oldest
// result (EBCDIC byte, status, last-of-character flag) is on the out_ ports and
// is taken at a rising edge with out_pop high.
// Each complete character gives one to five output bytes; an illegal sequence
// or a character cut off at buffer end gives one error beat with a zero byte.
// A result passes through the command queue, the encoder's command register
// and the output register. Throughput: the decoder takes one byte per cycle
// while the queue has room, the encoder issues one output byte per cycle while
// the receiver pops, so sustained rate is set by the encoder's serialisation.
// A two-entry command queue separates the decoder from the encoder, so the
// input keeps flowing for a while when the receiver stalls; in_full rises when
// that queue fills. Reset (rst_n low, synchronous) empties the queue and the
// output register and returns the decoder to expecting a lead byte.
module utf8_to_utf_ebcdic_converter (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_buffer,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_byte,
  output logic [1:0] out_status,
  output logic       out_last_of_char
);
  import u2e_pkg::*;

  logic byte_accept;
  logic cmd_push, cmd_full, cmd_empty, cmd_pop;
  cmd_t cmd_in, cmd_out;

  assign in_full     = cmd_full;
  assign byte_accept = in_push && !cmd_full;

  u2e_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .byte_accept      (byte_accept),
    .in_byte          (in_byte),
    .in_end_of_buffer (in_end_of_buffer),
    .cmd_push         (cmd_push),
    .cmd_data         (cmd_in)
  );

  u2e_cmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd_in),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .empty     (cmd_empty),
    .pop_data  (cmd_out)
  );

  u2e_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_empty        (cmd_empty),
    .cmd_data         (cmd_out),
    .cmd_pop          (cmd_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_byte         (out_byte),
    .out_status       (out_status),
    .out_last_of_char (out_last_of_char)
  );

  // An error beat always carries a zero byte and closes its character.
  a_error_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_status != ST_OK)) |-> ((out_byte == 8'd0) && out_last_of_char))
    else $error("error beat with non-zero byte or without last flag");

  // Only defined status codes reach the output.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> ((out_status == ST_OK) || (out_status == ST_ILLEGAL) ||
                    (out_status == ST_INCOMPLETE)))
    else $error("undefined status code on output");

  // The decoder never issues a command into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_push |-> !cmd_full)
    else $error("command pushed into a full queue");

  // A waiting result is not withdrawn while the receiver stalls.
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> !out_empty)
    else $error("waiting result lost while stalled");

endmodule

// ===== design/u2e_front.sv =====
// UTF-8 decoder: checks each input byte, gathers code points and issues encoder commands.
module u2e_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          byte_accept,
  input  logic [7:0]    in_byte,
  input  logic          in_end_of_buffer,
  output logic          cmd_push,
  output u2e_pkg::cmd_t cmd_data
);
  import u2e_pkg::*;

  logic [20:0] acc_r, acc_nxt;
  logic [1:0]  rem_r, rem_nxt;
  logic [7:0]  lead_r, lead_nxt;
  logic        second_r, second_nxt;
  logic [7:0]  lo, hi;
  logic [20:0] cp_next;

  // Build a character command: reject noncharacters, surrogates and
  // out-of-range values, otherwise work out the I8 length.
  function automatic cmd_t make_char(input logic [20:0] cp);
    cmd_t c;
    logic bad;
    bad = (cp[15:0] == 16'hFFFE) || (cp[15:0] == 16'hFFFF) || (cp > 21'h10FFFF) ||
          ((cp >= 21'h00D800) && (cp <= 21'h00DFFF)) ||
          ((cp >= 21'h00FDD0) && (cp <= 21'h00FDEF));
    c.cp = cp;
    if (bad) begin
      c.status = ST_ILLEGAL;
      c.trail  = 3'd0;
    end else begin
      c.status = ST_OK;
      if (cp <= 21'h00009F) c.trail = 3'd0;
      else if (cp <= 21'h0003FF) c.trail = 3'd1;
      else if (cp <= 21'h003FFF) c.trail = 3'd2;
      else if (cp <= 21'h03FFFF) c.trail = 3'd3;
      else c.trail = 3'd4;
    end
    return c;
  endfunction

  function automatic cmd_t make_error(input logic [1:0] code);
    cmd_t c;
    c.status = code;
    c.cp     = '0;
    c.trail  = 3'd0;
    return c;
  endfunction

  // Range of the second byte depends on the lead byte.
  always_comb begin
    lo = 8'h80;
    hi = 8'hBF;
    if (second_r) begin
      case (lead_r)
        8'hE0:   lo = 8'hA0;
        8'hED:   hi = 8'h9F;
        8'hF0:   lo = 8'h90;
        8'hF4:   hi = 8'h8F;
        default: ;
      endcase
    end
  end

  assign cp_next = {acc_r[14:0], in_byte[5:0]};

  // Decoding step for each accepted beat.
  always_comb begin
    acc_nxt    = acc_r;
    rem_nxt    = rem_r;
    lead_nxt   = lead_r;
    second_nxt = second_r;
    cmd_push   = 1'b0;
    cmd_data   = make_error(ST_ILLEGAL);
    if (byte_accept) begin
      if (rem_r == 2'd0) begin
        if (in_byte <= 8'h7F) begin
          cmd_push = 1'b1;
          cmd_data = make_char({13'd0, in_byte});
        end else if (!(in_byte inside {[8'hC2:8'hF4]})) begin
          cmd_push = 1'b1;
          cmd_data = make_error(ST_ILLEGAL);
        end else if (in_end_of_buffer) begin
          cmd_push = 1'b1;
          cmd_data = make_error(ST_INCOMPLETE);
        end else begin
          lead_nxt   = in_byte;
          second_nxt = 1'b1;
          if (in_byte inside {[8'hC2:8'hDF]}) begin
            rem_nxt = 2'd1;
            acc_nxt = {16'd0, in_byte[4:0]};
          end else if (in_byte inside {[8'hE0:8'hEF]}) begin
            rem_nxt = 2'd2;
            acc_nxt = {17'd0, in_byte[3:0]};
          end else begin
            rem_nxt = 2'd3;
            acc_nxt = {18'd0, in_byte[2:0]};
          end
        end
      end else if (in_end_of_buffer && (rem_r > 2'd1)) begin
        cmd_push = 1'b1;
        cmd_data = make_error(ST_INCOMPLETE);
      end else if ((in_byte < lo) || (in_byte > hi)) begin
        cmd_push = 1'b1;
        cmd_data = make_error(ST_ILLEGAL);
      end else begin
        acc_nxt    = cp_next;
        second_nxt = 1'b0;
        rem_nxt    = rem_r - 2'd1;
        if (rem_r == 2'd1) begin
          cmd_push = 1'b1;
          cmd_data = make_char(cp_next);
        end
      end
      // Any result ends the character and returns to lead-byte state.
      if (cmd_push) begin
        acc_nxt    = '0;
        rem_nxt    = 2'd0;
        lead_nxt   = 8'd0;
        second_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      rem_r    <= 2'd0;
      lead_r   <= 8'd0;
      second_r <= 1'b0;
    end else begin
      acc_r    <= acc_nxt;
      rem_r    <= rem_nxt;
      lead_r   <= lead_nxt;
      second_r <= second_nxt;
    end
  end

endmodule

// ===== design/u2e_cmd_fifo.sv =====
// Short command queue between the decoder and the encoder.
module u2e_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  u2e_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output u2e_pkg::cmd_t pop_data
);
  import u2e_pkg::*;

  cmd_t                 slot_r [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CMD_CNT_W-1:0] count_r;
  logic                 do_push, do_pop;

  assign full     = (count_r == CMD_CNT_W'(CMD_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = slot_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop) count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_data;
  end

endmodule

// ===== design/u2e_back.sv =====
// UTF-EBCDIC encoder: serialises each command into I8 bytes, maps them and drives the output register.
module u2e_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_empty,
  input  u2e_pkg::cmd_t cmd_data,
  output logic          cmd_pop,
  output logic          out_empty,
  input  logic          out_pop,
  output logic [7:0]    out_byte,
  output logic [1:0]    out_status,
  output logic          out_last_of_char
);
  import u2e_pkg::*;

  logic       cur_valid_r;
  cmd_t       cur_r;
  logic       lead_r;
  logic [2:0] rem_r;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic [1:0] out_status_r;
  logic       out_last_r;
  logic       step;
  logic       last;
  logic [7:0] i8;
  logic [4:0] trail_bits;

  // A byte is produced whenever there is work and room in the output register.
  assign step    = cur_valid_r && (!out_valid_r || out_pop);
  assign cmd_pop = !cmd_empty && (!cur_valid_r || (step && last));

  // Five payload bits for the next trailer.
  always_comb begin
    case (rem_r)
      3'd1:    trail_bits = cur_r.cp[4:0];
      3'd2:    trail_bits = cur_r.cp[9:5];
      3'd3:    trail_bits = cur_r.cp[14:10];
      3'd4:    trail_bits = cur_r.cp[19:15];
      default: trail_bits = cur_r.cp[4:0];
    endcase
  end

  // Current I8 byte: lead first, then trailers.
  always_comb begin
    if (lead_r) begin
      last = (cur_r.trail == 3'd0);
      case (cur_r.trail)
        3'd0:    i8 = cur_r.cp[7:0];
        3'd1:    i8 = {3'b110, cur_r.cp[9:5]};
        3'd2:    i8 = {4'b1110, cur_r.cp[13:10]};
        3'd3:    i8 = {5'b11110, cur_r.cp[17:15]};
        default: i8 = {6'b111110, 1'b0, cur_r.cp[20]};
      endcase
    end else begin
      last = (rem_r == 3'd1);
      i8   = {3'b101, trail_bits};
    end
    if (cur_r.status != ST_OK) last = 1'b1;
  end

  // Command sequencing.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      lead_r      <= 1'b0;
      rem_r       <= 3'd0;
    end else begin
      if (cmd_pop) begin
        cur_valid_r <= 1'b1;
        cur_r       <= cmd_data;
        lead_r      <= 1'b1;
        rem_r       <= cmd_data.trail;
      end else if (step) begin
        if (last) cur_valid_r <= 1'b0;
        else if (lead_r) lead_r <= 1'b0;
        else rem_r <= rem_r - 3'd1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_byte_r   <= (cur_r.status == ST_OK) ? I8_ROM[i8] : 8'd0;
      out_status_r <= cur_r.status;
      out_last_r   <= last;
    end
  end

  assign out_empty        = !out_valid_r;
  assign out_byte         = out_byte_r;
  assign out_status       = out_status_r;
  assign out_last_of_char = out_last_r;

endmodule

// ===== sim/utf8_to_utf_ebcdic_converter_tb.sv =====
// Self-checking testbench for the UTF-8 to UTF-EBCDIC converter.
`timescale 1ns / 100ps

module utf8_to_utf_ebcdic_converter_tb;
  import u2e_pkg::*;

  // One output beat: EBCDIC byte, status and end-of-character flag.
  typedef struct packed {
    logic [7:0] data;
    logic [1:0] status;
    logic       last;
  } ebcdic_beat_t;

  // One directed input beat; known marks a row whose single result is typed in.
  typedef struct packed {
    logic [7:0]   data;
    logic         eob;
    logic         known;
    ebcdic_beat_t want;
  } directed_row_t;

  localparam int RANDOM_ITEMS = 450;
  localparam int IDLE_PERCENT = 18;
  localparam int HOLD_CYCLES  = 60;
  localparam int HOLD_AT      = 150;
  localparam int STEADY_FROM  = 300;
  localparam int STEADY_TO    = 380;
  localparam int STALL_LIMIT  = 1000;
  localparam int SETTLE       = 8;

  localparam ebcdic_beat_t NONE     = '0;
  localparam ebcdic_beat_t BAD_SEQ  = '{8'h00, ST_ILLEGAL, 1'b1};
  localparam ebcdic_beat_t CUT_OFF  = '{8'h00, ST_INCOMPLETE, 1'b1};

  // I8 byte to EBCDIC byte, as defined by UTR#16.
  localparam logic [7:0] EBCDIC_OF_I8 [256] = '{
    8'h00,8'h01,8'h02,8'h03,8'h37,8'h2D,8'h2E,8'h2F,8'h16,8'h05,8'h15,8'h0B,8'h0C,8'h0D,8'h0E,8'h0F,
    8'h10,8'h11,8'h12,8'h13,8'h3C,8'h3D,8'h32,8'h26,8'h18,8'h19,8'h3F,8'h27,8'h1C,8'h1D,8'h1E,8'h1F,
    8'h40,8'h5A,8'h7F,8'h7B,8'h5B,8'h6C,8'h50,8'h7D,8'h4D,8'h5D,8'h5C,8'h4E,8'h6B,8'h60,8'h4B,8'h61,
    8'hF0,8'hF1,8'hF2,8'hF3,8'hF4,8'hF5,8'hF6,8'hF7,8'hF8,8'hF9,8'h7A,8'h5E,8'h4C,8'h7E,8'h6E,8'h6F,
    8'h7C,8'hC1,8'hC2,8'hC3,8'hC4,8'hC5,8'hC6,8'hC7,8'hC8,8'hC9,8'hD1,8'hD2,8'hD3,8'hD4,8'hD5,8'hD6,
    8'hD7,8'hD8,8'hD9,8'hE2,8'hE3,8'hE4,8'hE5,8'hE6,8'hE7,8'hE8,8'hE9,8'hAD,8'hE0,8'hBD,8'h5F,8'h6D,
    8'h79,8'h81,8'h82,8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,8'h91,8'h92,8'h93,8'h94,8'h95,8'h96,
    8'h97,8'h98,8'h99,8'hA2,8'hA3,8'hA4,8'hA5,8'hA6,8'hA7,8'hA8,8'hA9,8'hC0,8'h4F,8'hD0,8'hA1,8'h07,
    8'h20,8'h21,8'h22,8'h23,8'h24,8'h25,8'h06,8'h17,8'h28,8'h29,8'h2A,8'h2B,8'h2C,8'h09,8'h0A,8'h1B,
    8'h30,8'h31,8'h1A,8'h33,8'h34,8'h35,8'h36,8'h08,8'h38,8'h39,8'h3A,8'h3B,8'h04,8'h14,8'h3E,8'hFF,
    8'h41,8'h42,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,8'h4A,8'h51,8'h52,8'h53,8'h54,8'h55,8'h56,
    8'h57,8'h58,8'h59,8'h62,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,8'h6A,8'h70,8'h71,8'h72,8'h73,
    8'h74,8'h75,8'h76,8'h77,8'h78,8'h80,8'h8A,8'h8B,8'h8C,8'h8D,8'h8E,8'h8F,8'h90,8'h9A,8'h9B,8'h9C,
    8'h9D,8'h9E,8'h9F,8'hA0,8'hAA,8'hAB,8'hAC,8'hAE,8'hAF,8'hB0,8'hB1,8'hB2,8'hB3,8'hB4,8'hB5,8'hB6,
    8'hB7,8'hB8,8'hB9,8'hBA,8'hBB,8'hBC,8'hBE,8'hBF,8'hCA,8'hCB,8'hCC,8'hCD,8'hCE,8'hCF,8'hDA,8'hDB,
    8'hDC,8'hDD,8'hDE,8'hDF,8'hE1,8'hEA,8'hEB,8'hEC,8'hED,8'hEE,8'hEF,8'hFA,8'hFB,8'hFC,8'hFD,8'hFE
  };

  // Directed beats: extremes, illegal leads and continuations, rejected code
  // points and characters cut off at the end of the buffer.
  localparam directed_row_t DIRECTED [27] = '{
    '{8'h00, 1'b0, 1'b1, '{8'h00, ST_OK, 1'b1}},
    '{8'h7F, 1'b1, 1'b1, '{8'h07, ST_OK, 1'b1}},
    '{8'h80, 1'b0, 1'b1, BAD_SEQ},
    '{8'hFF, 1'b1, 1'b1, BAD_SEQ},
    '{8'hC2, 1'b1, 1'b1, CUT_OFF},
    '{8'hC2, 1'b0, 1'b0, NONE},
    '{8'h80, 1'b0, 1'b0, NONE},
    '{8'hDF, 1'b0, 1'b0, NONE},
    '{8'hBF, 1'b0, 1'b0, NONE},
    '{8'hE0, 1'b0, 1'b0, NONE},
    '{8'h9F, 1'b0, 1'b1, BAD_SEQ},
    '{8'hED, 1'b0, 1'b0, NONE},
    '{8'hA0, 1'b0, 1'b1, BAD_SEQ},
    '{8'hEF, 1'b0, 1'b0, NONE},
    '{8'hBF, 1'b0, 1'b0, NONE},
    '{8'hBE, 1'b0, 1'b1, BAD_SEQ},
    '{8'hEF, 1'b0, 1'b0, NONE},
    '{8'hB7, 1'b0, 1'b0, NONE},
    '{8'h90, 1'b1, 1'b1, BAD_SEQ},
    '{8'hF4, 1'b0, 1'b0, NONE},
    '{8'h8F, 1'b0, 1'b0, NONE},
    '{8'hBF, 1'b0, 1'b0, NONE},
    '{8'hBD, 1'b0, 1'b0, NONE},
    '{8'hF0, 1'b0, 1'b0, NONE},
    '{8'h8F, 1'b0, 1'b1, BAD_SEQ},
    '{8'hE1, 1'b0, 1'b0, NONE},
    '{8'h00, 1'b1, 1'b1, CUT_OFF}
  };

  // Code points on the I8 length boundaries and around the rejected ranges.
  localparam logic [20:0] EDGE_CPS [19] = '{
    21'h00007F, 21'h000080, 21'h00009F, 21'h0000A0, 21'h0003FF, 21'h000400,
    21'h0007FF, 21'h000800, 21'h003FFF, 21'h004000, 21'h00D7FF, 21'h00E000,
    21'h00FDD0, 21'h00FDEF, 21'h00FFFE, 21'h00FFFF, 21'h03FFFF, 21'h040000,
    21'h10FFFF
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_push = 1'b0;
  logic       in_full;
  logic [7:0] in_byte = 8'h00;
  logic       in_end_of_buffer = 1'b0;
  logic       out_empty;
  logic       out_pop = 1'b0;
  logic [7:0] out_byte;
  logic [1:0] out_status;
  logic       out_last_of_char;

  utf8_to_utf_ebcdic_converter DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_byte          (in_byte),
    .in_end_of_buffer (in_end_of_buffer),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_byte         (out_byte),
    .out_status       (out_status),
    .out_last_of_char (out_last_of_char)
  );

  always #10 clk = ~clk;

  // Decoder state mirrored from the block.
  logic [20:0] acc_cp = '0;
  logic [1:0]  trail_left = '0;
  logic [7:0]  lead_held = '0;
  logic        second_next = 1'b0;

  ebcdic_beat_t pending_ebcdic [$];
  ebcdic_beat_t char_ebcdic [$];
  int           fault_count = 0;
  int           random_sent = 0;
  bit           hold_req = 1'b0;
  bit           steady = 1'b0;
  int unsigned  quiet_cycles = 0;

  function automatic void drop_char(input logic [1:0] code);
    acc_cp = '0;
    trail_left = '0;
    lead_held = '0;
    second_next = 1'b0;
    char_ebcdic.push_back('{8'h00, code, 1'b1});
  endfunction

  // Checks a gathered code point and writes it out as I8, mapped to EBCDIC.
  function automatic void emit_code_point(input logic [20:0] cp);
    logic [7:0] i8 [5];
    int n;
    if (cp[15:0] == 16'hFFFE || cp[15:0] == 16'hFFFF || cp > 21'h10FFFF ||
        (cp >= 21'h00D800 && cp <= 21'h00DFFF) ||
        (cp >= 21'h00FDD0 && cp <= 21'h00FDEF)) begin
      drop_char(ST_ILLEGAL);
      return;
    end
    if (cp <= 21'h00009F) begin
      i8[0] = cp[7:0];
      n = 1;
    end else if (cp <= 21'h0003FF) begin
      i8[0] = 8'hC0 | 8'((cp >> 5) & 21'h1F);
      n = 2;
    end else if (cp <= 21'h003FFF) begin
      i8[0] = 8'hE0 | 8'((cp >> 10) & 21'h0F);
      n = 3;
    end else if (cp <= 21'h03FFFF) begin
      i8[0] = 8'hF0 | 8'((cp >> 15) & 21'h07);
      n = 4;
    end else begin
      i8[0] = 8'hF8 | 8'((cp >> 20) & 21'h03);
      n = 5;
    end
    for (int k = 1; k < n; k++) begin
      i8[k] = 8'hA0 | 8'((cp >> (5 * (n - 1 - k))) & 21'h1F);
    end
    for (int k = 0; k < n; k++) begin
      char_ebcdic.push_back('{EBCDIC_OF_I8[i8[k]], ST_OK, (k == n - 1)});
    end
  endfunction

  // Works out the beats that one accepted UTF-8 byte causes.
  function automatic void transcode_utf8_byte(input logic [7:0] b, input logic eob);
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [1:0]  need;
    logic [20:0] acc;
    lo = 8'h80;
    hi = 8'hBF;
    if (trail_left == 2'd0) begin
      if (b <= 8'h7F) begin
        emit_code_point({13'd0, b});
        return;
      end
      if (b >= 8'hC2 && b <= 8'hDF) begin
        need = 2'd1;
        acc = {16'd0, b[4:0]};
      end else if (b >= 8'hE0 && b <= 8'hEF) begin
        need = 2'd2;
        acc = {17'd0, b[3:0]};
      end else if (b >= 8'hF0 && b <= 8'hF4) begin
        need = 2'd3;
        acc = {18'd0, b[2:0]};
      end else begin
        drop_char(ST_ILLEGAL);
        return;
      end
      if (eob) begin
        drop_char(ST_INCOMPLETE);
        return;
      end
      acc_cp = acc;
      trail_left = need;
      lead_held = b;
      second_next = 1'b1;
      return;
    end
    // A buffer end before the final continuation cuts the character off.
    if (eob && trail_left > 2'd1) begin
      drop_char(ST_INCOMPLETE);
      return;
    end
    if (second_next) begin
      case (lead_held)
        8'hE0: lo = 8'hA0;
        8'hED: hi = 8'h9F;
        8'hF0: lo = 8'h90;
        8'hF4: hi = 8'h8F;
        default: ;
      endcase
    end
    if (b < lo || b > hi) begin
      drop_char(ST_ILLEGAL);
      return;
    end
    acc_cp = {acc_cp[14:0], b[5:0]};
    second_next = 1'b0;
    trail_left = trail_left - 2'd1;
    if (trail_left != 2'd0) return;
    acc = acc_cp;
    acc_cp = '0;
    lead_held = '0;
    emit_code_point(acc);
  endfunction

  // Offers one byte until it is taken, then records the beats it is owed.
  task automatic offer_byte(input logic [7:0] b, input logic eob, input logic known,
                            input ebcdic_beat_t want);
    while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_byte <= b;
    in_end_of_buffer <= eob;
    do @(posedge clk); while (in_full);
    char_ebcdic.delete();
    transcode_utf8_byte(b, eob);
    if (known) begin
      pending_ebcdic.push_back(want);
    end else begin
      foreach (char_ebcdic[k]) pending_ebcdic.push_back(char_ebcdic[k]);
    end
  endtask

  // Sends one random character: mostly well-formed UTF-8, some noise and
  // some truncated or corrupted sequences, with the odd buffer end.
  task automatic send_random_char();
    logic [7:0]  seq [$];
    logic [20:0] cp;
    int          pick;
    int          idx;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      seq.push_back(8'($urandom_range(0, 255)));
    end else begin
      if (pick < 24) begin
        cp = EDGE_CPS[$urandom_range(0, 18)];
      end else begin
        case ($urandom_range(0, 3))
          0: cp = 21'($urandom_range(0, 21'h7F));
          1: cp = 21'($urandom_range(21'h80, 21'h7FF));
          2: cp = 21'($urandom_range(21'h800, 21'hFFFF));
          default: cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
        endcase
      end
      if (cp < 21'h80) begin
        seq.push_back(cp[7:0]);
      end else if (cp < 21'h800) begin
        seq.push_back({3'b110, cp[10:6]});
        seq.push_back({2'b10, cp[5:0]});
      end else if (cp < 21'h10000) begin
        seq.push_back({4'b1110, cp[15:12]});
        seq.push_back({2'b10, cp[11:6]});
        seq.push_back({2'b10, cp[5:0]});
      end else begin
        seq.push_back({5'b11110, cp[20:18]});
        seq.push_back({2'b10, cp[17:12]});
        seq.push_back({2'b10, cp[11:6]});
        seq.push_back({2'b10, cp[5:0]});
      end
      // Break a few multi-byte sequences.
      if (seq.size() > 1 && $urandom_range(0, 99) < 10) begin
        if ($urandom_range(0, 1) == 0) begin
          void'(seq.pop_back());
        end else begin
          idx = $urandom_range(1, seq.size() - 1);
          seq[idx] = 8'($urandom_range(0, 255));
        end
      end
    end
    foreach (seq[k]) begin
      offer_byte(seq[k], $urandom_range(0, 99) < 4, 1'b0, NONE);
      random_sent++;
      if (random_sent == HOLD_AT) hold_req = 1'b1;
      steady = (random_sent >= STEADY_FROM && random_sent < STEADY_TO);
    end
  endtask

  // Result side: checks each popped beat against the oldest owed beat.
  initial begin : result_side
    ebcdic_beat_t got;
    ebcdic_beat_t want;
    bit           held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) begin
        got = '{out_byte, out_status, out_last_of_char};
        if (pending_ebcdic.size() == 0) begin
          $display("%0t: unexpected beat, byte %h status %0d last %0b",
                   $time, got.data, got.status, got.last);
          fault_count++;
        end else begin
          want = pending_ebcdic.pop_front();
          if (got !== want) begin
            $display("%0t: beat mismatch, expected byte %h status %0d last %0b, got byte %h status %0d last %0b",
                     $time, want.data, want.status, want.last,
                     got.data, got.status, got.last);
            fault_count++;
          end
        end
      end
      // One long hold-off lets the block fill up and stall its input.
      if (hold_req && !held) begin
        held = 1'b1;
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_pop <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
    end
  end

  // Watchdog: ends the run when neither side has moved a beat for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("utf8_to_utf_ebcdic_converter test failed");
      $finish;
    end
  end

  // Stimulus: reset, the directed table, then random characters.
  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    foreach (DIRECTED[i]) begin
      offer_byte(DIRECTED[i].data, DIRECTED[i].eob, DIRECTED[i].known, DIRECTED[i].want);
    end
    while (random_sent < RANDOM_ITEMS) send_random_char();
    in_push <= 1'b0;
    while (pending_ebcdic.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (fault_count == 0 && pending_ebcdic.size() == 0) begin
      $display("utf8_to_utf_ebcdic_converter test passed");
    end else begin
      $display("utf8_to_utf_ebcdic_converter test failed");
    end
    $finish;
  end

endmodule
